[src/ibhq_pkg.sv]
// ---------------------------------------------------------------------------
// ibhq_pkg: shared types and constants of the indexed binary heap queue
// Operation, status and colour codes, default sizes and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package ibhq_pkg;

   localparam int CAPACITY_DEFAULT  = 1024;
   localparam int COST_BITS_DEFAULT = 32;

   // Element numbers arrive on a 10-bit field, so at most this many exist.
   localparam int ELEM_LIMIT   = 1024;
   localparam int ELEM_W       = 10;
   localparam int COST_IN_W    = 32;
   localparam int COUNT_W      = 11;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // Register index within the configuration space.
   localparam int REG_MAX_FIRST = 0;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_REMOVED   = 3'd3,
      STATUS_NOT_WHITE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      COLOR_WHITE   = 2'd0,
      COLOR_QUEUED  = 2'd1,
      COLOR_REMOVED = 2'd2
   } color_type;

   typedef struct packed {
      logic       latch_req;
      logic       sweep_start;
      logic       sweep_step;
      logic       rd_entry;
      logic       write_cost;
      logic       push;
      logic       set_status;
      status_type status_code;
      logic       load_top;
      logic       rm_start;
      logic       rm_top_cost;
      logic       rm_mcost;
      logic       queued_up;
      logic       up_read_parent;
      logic       up_read_cost;
      logic       up_move;
      logic       place;
      logic       dn_start;
      logic       dn_left;
      logic       dn_right;
      logic       dn_rcmp;
      logic       dn_move;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic      clear_pending;
      kind_type  kind;
      logic      elem_ok;
      color_type color;
      logic      heap_full;
      logic      heap_empty;
      logic      pos_zero;
      logic      left_in;
      logic      right_in;
      logic      up_better;
      logic      best_is_pos;
      logic      sweep_last;
      logic      rsp_free;
   } stat_type;

endpackage

[src/indexed_binary_heap_queue.sv]
// ---------------------------------------------------------------------------
// indexed_binary_heap_queue: indexed binary heap priority queue
// Insert, remove-top, cost update and clear over a fixed set of elements.
// ---------------------------------------------------------------------------
// Requests arrive on the req_ stream: tuser carries the operation kind, tdata
// the element number and its signed Q16.16 cost. Every request gives exactly
// one response on the rsp_ stream with status, removed element and cost,
// and the empty, full and count flags after the operation.
// One request is handled at a time. Insert and update climb the element one
// heap level per sift step; remove sinks it one level per step (at most
// log2 of the capacity levels). Each sift step is bound by the single read
// port of the heap and cost memories. Clear, or a change of the order
// register, sweeps the colour store at one entry per cycle, over every
// element number (1024 by default).
// After reset the same sweep runs before the first request is taken.
// The response sits in an output register; while the receiver stalls the
// next request is still accepted and worked on, and it waits only for that
// register to drain. The csr_ port holds max_first at byte address 0.
// ---------------------------------------------------------------------------
module indexed_binary_heap_queue #(
   parameter int CAPACITY  = ibhq_pkg::CAPACITY_DEFAULT,
   parameter int COST_BITS = ibhq_pkg::COST_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // element_index [9:0], cost_value [41:10], zero fill above
   input  logic [ibhq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind [1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status [2:0], top_element [12:3], top_cost [44:13], is_empty [45],
   // is_full [46], count [57:47], zero fill above
   output logic [ibhq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ibhq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ibhq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ibhq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   ibhq_pkg::cmd_type  cmd;
   ibhq_pkg::stat_type stat;
   logic               max_first, cfg_we, reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == 1'(ibhq_pkg::REG_MAX_FIRST));
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign csr_prdata = reg_sel ? {31'b0, max_first} : '0;

   ibhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ibhq_datapath #(
      .CAPACITY  (CAPACITY),
      .COST_BITS (COST_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_elem   (req_tdata[9:0]),
      .req_cost   (req_tdata[41:10]),
      .cfg_we     (cfg_we),
      .cfg_value  (csr_pwdata[0]),
      .max_first  (max_first),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule

[src/ibhq_ctrl.sv]
// ---------------------------------------------------------------------------
// ibhq_ctrl: operation sequencer of the heap queue
// Steps through decode, sift up, sift down and the colour sweep, issuing
// one command bundle per cycle to the datapath.
// ---------------------------------------------------------------------------
module ibhq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ibhq_pkg::stat_type stat,
   output ibhq_pkg::cmd_type  cmd
);

   typedef enum logic [17:0] {
      S_INIT  = 18'd1 << 0,
      S_IDLE  = 18'd1 << 1,
      S_RD    = 18'd1 << 2,
      S_DEC   = 18'd1 << 3,
      S_CLR   = 18'd1 << 4,
      S_RM1   = 18'd1 << 5,
      S_RM2   = 18'd1 << 6,
      S_RM3   = 18'd1 << 7,
      S_UP    = 18'd1 << 8,
      S_UP2   = 18'd1 << 9,
      S_UP3   = 18'd1 << 10,
      S_PLACE = 18'd1 << 11,
      S_DN    = 18'd1 << 12,
      S_DN2   = 18'd1 << 13,
      S_DN3   = 18'd1 << 14,
      S_DN4   = 18'd1 << 15,
      S_DNM   = 18'd1 << 16,
      S_DONE  = 18'd1 << 17
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE) && !stat.clear_pending;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (stat.clear_pending) begin
               cmd.sweep_start = 1'b1;
               state_in        = S_INIT;
            end else if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_entry = 1'b1;
            state_in     = S_DEC;
         end
         S_DEC: begin
            state_in = S_DONE;
            case (stat.kind)
               ibhq_pkg::KIND_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  state_in        = S_CLR;
               end
               ibhq_pkg::KIND_REMOVE: begin
                  if (stat.heap_empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ibhq_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.load_top = 1'b1;
                     state_in     = S_RM1;
                  end
               end
               ibhq_pkg::KIND_INSERT: begin
                  if (!stat.elem_ok || (stat.color == ibhq_pkg::COLOR_WHITE
                                        && stat.heap_full)) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ibhq_pkg::STATUS_FULL;
                  end else if (stat.color != ibhq_pkg::COLOR_WHITE) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ibhq_pkg::STATUS_NOT_WHITE;
                  end else begin
                     cmd.write_cost = 1'b1;
                     cmd.push       = 1'b1;
                     state_in       = S_UP;
                  end
               end
               default: begin
                  if (!stat.elem_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ibhq_pkg::STATUS_FULL;
                  end else begin
                     cmd.write_cost = 1'b1;
                     if (stat.color == ibhq_pkg::COLOR_REMOVED) begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ibhq_pkg::STATUS_REMOVED;
                     end else if (stat.color == ibhq_pkg::COLOR_WHITE) begin
                        if (stat.heap_full) begin
                           cmd.set_status  = 1'b1;
                           cmd.status_code = ibhq_pkg::STATUS_FULL;
                        end else begin
                           cmd.push = 1'b1;
                           state_in = S_UP;
                        end
                     end else begin
                        cmd.queued_up = 1'b1;
                        state_in      = S_UP;
                     end
                  end
               end
            endcase
         end
         S_CLR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) state_in = S_DONE;
         end
         S_RM1: begin
            cmd.rm_start = 1'b1;
            state_in     = S_RM2;
         end
         S_RM2: begin
            cmd.rm_top_cost = 1'b1;
            state_in        = S_RM3;
         end
         S_RM3: begin
            cmd.rm_mcost = 1'b1;
            state_in     = stat.heap_empty ? S_DONE : S_DN;
         end
         S_UP: begin
            if (stat.pos_zero) begin
               state_in = S_PLACE;
            end else begin
               cmd.up_read_parent = 1'b1;
               state_in           = S_UP2;
            end
         end
         S_UP2: begin
            cmd.up_read_cost = 1'b1;
            state_in         = S_UP3;
         end
         S_UP3: begin
            if (stat.up_better) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_DONE;
         end
         S_DN: begin
            if (!stat.left_in) begin
               state_in = S_PLACE;
            end else begin
               cmd.dn_start = 1'b1;
               state_in     = S_DN2;
            end
         end
         S_DN2: begin
            cmd.dn_left = 1'b1;
            state_in    = S_DN3;
         end
         S_DN3: begin
            cmd.dn_right = 1'b1;
            state_in     = stat.right_in ? S_DN4 : S_DNM;
         end
         S_DN4: begin
            cmd.dn_rcmp = 1'b1;
            state_in    = S_DNM;
         end
         S_DNM: begin
            if (stat.best_is_pos) begin
               state_in = S_PLACE;
            end else begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

endmodule

[src/ibhq_datapath.sv]
// ---------------------------------------------------------------------------
// ibhq_datapath: heap memories, working registers and result register
// Holds the cost, slot, position and colour stores, the moving element of a
// sift, the element count, the order register and the output stage.
// ---------------------------------------------------------------------------
module ibhq_datapath #(
   parameter int CAPACITY  = ibhq_pkg::CAPACITY_DEFAULT,
   parameter int COST_BITS = ibhq_pkg::COST_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ibhq_pkg::cmd_type                   cmd,
   output ibhq_pkg::stat_type                  stat,
   input  logic [1:0]                          req_kind,
   input  logic [ibhq_pkg::ELEM_W-1:0]         req_elem,
   input  logic signed [ibhq_pkg::COST_IN_W-1:0] req_cost,
   input  logic                                cfg_we,
   input  logic                                cfg_value,
   output logic                                max_first,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ibhq_pkg::RSP_DATA_W-1:0]     rsp_data
);

   localparam int  ELEM  = (CAPACITY < ibhq_pkg::ELEM_LIMIT) ? CAPACITY
                                                            : ibhq_pkg::ELEM_LIMIT;
   localparam int  SW    = $clog2(ELEM);
   localparam int  CW    = $clog2(ELEM + 1);
   localparam bit  FULL_REACHABLE = (CAPACITY <= ibhq_pkg::ELEM_LIMIT);

   typedef logic signed [COST_BITS-1:0] cost_type;

   function automatic logic better(input cost_type a, input cost_type b, input logic mx);
      return mx ? (a > b) : (a < b);
   endfunction

   // Stores
   cost_type             cost_mem  [ELEM];
   logic [SW-1:0]        heap_mem  [ELEM];
   logic [SW-1:0]        slot_mem  [ELEM];
   ibhq_pkg::color_type  color_mem [ELEM];

   cost_type             cost_rd_ff;
   logic [SW-1:0]        heap_rd_ff, slot_rd_ff;
   ibhq_pkg::color_type  color_rd_ff;

   // Working registers
   ibhq_pkg::kind_type   kind_ff, kind_in;
   logic [ibhq_pkg::ELEM_W-1:0] elem_ff, elem_in;
   cost_type             fit_ff, fit_in, mcost_ff, mcost_in, best_cost_ff, best_cost_in;
   ibhq_pkg::status_type status_ff, status_in;
   logic [SW-1:0]        top_el_ff, top_el_in, mel_ff, mel_in, pos_ff, pos_in;
   logic [SW-1:0]        cand_pos_ff, cand_pos_in, cand_el_ff, cand_el_in;
   logic [SW-1:0]        best_pos_ff, best_pos_in, best_el_ff, best_el_in;
   logic [SW-1:0]        rel_ff, rel_in, sweep_ff, sweep_in;
   logic [31:0]          top_cost_ff, top_cost_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 max_first_ff, max_first_in, pending_ff, pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ibhq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [63:0]   cost_ext, kept_ext;
   cost_type             cost_fit;
   logic [SW:0]          left_pos, right_pos;
   logic [SW-1:0]        parent_pos, heap_ra, cost_ra, heap_wd, color_wa;
   logic                 heap_we, color_we, heap_full, heap_empty, rsp_free;
   ibhq_pkg::color_type  color_wd;

   assign cost_ext   = 64'(req_cost);
   assign cost_fit   = cost_ext[COST_BITS-1:0];
   assign kept_ext   = 64'(cost_rd_ff);
   assign left_pos   = {pos_ff, 1'b1};
   assign right_pos  = left_pos + 1'b1;
   assign parent_pos = SW'((pos_ff - 1'b1) >> 1);
   assign heap_empty = (count_ff == '0);
   assign heap_full  = FULL_REACHABLE && (count_ff == CW'(ELEM));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      heap_ra = '0;
      if (cmd.rm_start)       heap_ra = SW'(count_ff - 1'b1);
      if (cmd.up_read_parent) heap_ra = parent_pos;
      if (cmd.dn_start)       heap_ra = left_pos[SW-1:0];
      if (cmd.dn_left)        heap_ra = right_pos[SW-1:0];
   end

   assign cost_ra = cmd.rm_start ? top_el_ff : heap_rd_ff;
   assign heap_we = cmd.up_move || cmd.place || cmd.dn_move;
   assign heap_wd = cmd.up_move ? cand_el_ff : (cmd.dn_move ? best_el_ff : mel_ff);

   always_comb begin
      color_we = 1'b1;
      color_wa = elem_ff[SW-1:0];
      color_wd = ibhq_pkg::COLOR_QUEUED;
      if (cmd.sweep_step) begin
         color_wa = sweep_ff;
         color_wd = ibhq_pkg::COLOR_WHITE;
      end else if (cmd.rm_start) begin
         color_wa = top_el_ff;
         color_wd = ibhq_pkg::COLOR_REMOVED;
      end else if (!cmd.push) begin
         color_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_cost) cost_mem[elem_ff[SW-1:0]] <= fit_ff;
      cost_rd_ff <= cost_mem[cost_ra];
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[pos_ff] <= heap_wd;
      heap_rd_ff <= heap_mem[heap_ra];
   end

   always_ff @(posedge clock) begin
      if (heap_we) slot_mem[heap_wd] <= pos_ff;
      slot_rd_ff <= slot_mem[elem_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (color_we) color_mem[color_wa] <= color_wd;
      color_rd_ff <= color_mem[elem_ff[SW-1:0]];
   end

   always_comb begin
      kind_in      = kind_ff;
      elem_in      = elem_ff;
      fit_in       = fit_ff;
      status_in    = status_ff;
      top_el_in    = top_el_ff;
      top_cost_in  = top_cost_ff;
      mel_in       = mel_ff;
      mcost_in     = mcost_ff;
      pos_in       = pos_ff;
      cand_pos_in  = cand_pos_ff;
      cand_el_in   = cand_el_ff;
      best_pos_in  = best_pos_ff;
      best_el_in   = best_el_ff;
      best_cost_in = best_cost_ff;
      rel_in       = rel_ff;
      sweep_in     = sweep_ff;
      count_in     = count_ff;
      max_first_in = max_first_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.latch_req) begin
         kind_in     = ibhq_pkg::kind_type'(req_kind);
         elem_in     = req_elem;
         fit_in      = cost_fit;
         status_in   = ibhq_pkg::STATUS_OK;
         top_el_in   = '0;
         top_cost_in = '0;
      end
      if (cmd.set_status) status_in = cmd.status_code;
      if (cmd.load_top)   top_el_in = heap_rd_ff;
      if (cmd.sweep_start) begin
         sweep_in   = '0;
         count_in   = '0;
         pending_in = 1'b0;
      end
      if (cmd.sweep_step) sweep_in = sweep_ff + 1'b1;
      if (cmd.push) begin
         mel_in   = elem_ff[SW-1:0];
         mcost_in = fit_ff;
         pos_in   = SW'(count_ff);
         count_in = count_ff + 1'b1;
      end
      if (cmd.queued_up) begin
         mel_in   = elem_ff[SW-1:0];
         mcost_in = fit_ff;
         pos_in   = slot_rd_ff;
      end
      if (cmd.rm_start) count_in = count_ff - 1'b1;
      if (cmd.rm_top_cost) begin
         top_cost_in = kept_ext[31:0];
         mel_in      = heap_rd_ff;
      end
      if (cmd.rm_mcost) begin
         mcost_in = cost_rd_ff;
         pos_in   = '0;
      end
      if (cmd.up_read_parent) cand_pos_in = parent_pos;
      if (cmd.up_read_cost)   cand_el_in  = heap_rd_ff;
      if (cmd.up_move)        pos_in      = cand_pos_ff;
      if (cmd.dn_start) begin
         best_pos_in  = pos_ff;
         best_el_in   = mel_ff;
         best_cost_in = mcost_ff;
      end
      if (cmd.dn_left) cand_el_in = heap_rd_ff;
      // The left child only wins when strictly better than the moving element.
      if (cmd.dn_right) begin
         rel_in = heap_rd_ff;
         if (better(cost_rd_ff, mcost_ff, max_first_ff)) begin
            best_pos_in  = left_pos[SW-1:0];
            best_el_in   = cand_el_ff;
            best_cost_in = cost_rd_ff;
         end
      end
      if (cmd.dn_rcmp && better(cost_rd_ff, best_cost_ff, max_first_ff)) begin
         best_pos_in  = right_pos[SW-1:0];
         best_el_in   = rel_ff;
         best_cost_in = cost_rd_ff;
      end
      if (cmd.dn_move) pos_in = best_pos_ff;

      if (cfg_we) begin
         max_first_in = cfg_value;
         if (cfg_value != max_first_ff) pending_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, ibhq_pkg::COUNT_W'(count_ff), heap_full, heap_empty,
                         top_cost_ff, ibhq_pkg::ELEM_W'(top_el_ff), status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_first_ff <= 1'b0;
         pending_ff   <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         max_first_ff <= max_first_in;
         pending_ff   <= pending_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      elem_ff      <= elem_in;
      fit_ff       <= fit_in;
      status_ff    <= status_in;
      top_el_ff    <= top_el_in;
      top_cost_ff  <= top_cost_in;
      mel_ff       <= mel_in;
      mcost_ff     <= mcost_in;
      pos_ff       <= pos_in;
      cand_pos_ff  <= cand_pos_in;
      cand_el_ff   <= cand_el_in;
      best_pos_ff  <= best_pos_in;
      best_el_ff   <= best_el_in;
      best_cost_ff <= best_cost_in;
      rel_ff       <= rel_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      stat.clear_pending = pending_ff;
      stat.kind          = kind_ff;
      stat.elem_ok       = (32'(elem_ff) < 32'(CAPACITY));
      stat.color         = color_rd_ff;
      stat.heap_full     = heap_full;
      stat.heap_empty    = heap_empty;
      stat.pos_zero      = (pos_ff == '0);
      stat.left_in       = ({1'b0, left_pos} < (SW + 2)'(count_ff));
      stat.right_in      = ({1'b0, right_pos} < (SW + 2)'(count_ff));
      stat.up_better     = better(mcost_ff, cost_rd_ff, max_first_ff);
      stat.best_is_pos   = (best_pos_ff == pos_ff);
      stat.sweep_last    = (sweep_ff == SW'(ELEM - 1));
      stat.rsp_free      = rsp_free;
   end

   assign max_first  = max_first_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ELEM))
      else $error("element count exceeds the store depth");

   a_push_white: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!heap_full && color_rd_ff == ibhq_pkg::COLOR_WHITE))
      else $error("push of a non-white element or into a full heap");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.sweep_start |=> (count_ff == $past(count_ff))
                        || (count_ff == $past(count_ff) + 1'b1)
                        || (count_ff == $past(count_ff) - 1'b1))
      else $error("element count moved by more than one");

endmodule
